@@ rtl/core/ssep_pkg.sv @@
`default_nettype none

package ssep_pkg;

  // Default coordinate width, raw two's complement bits.
  localparam int COORD_WIDTH_DEF = 32;

  typedef struct packed {
    logic tangent;
    logic degen;
  } ssep_flags_t;

endpackage

`default_nettype wire

@@ rtl/core/ssep_quad.sv @@
`default_nettype none

// Seven stages: differences, products, dot sums, magnitudes, split
// partial products, recombination, discriminant and clamp.
module ssep_quad #(
  parameter int W = ssep_pkg::COORD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2:0][W-1:0]   o_pt,
  input  logic [2:0][W-1:0]   p_pt,
  input  logic [2:0][W-1:0]   c_pt,
  input  logic [W-2:0]        rad,
  output logic                valid,
  output logic [4*W+3:0]      radicand,
  output logic                clamped,
  output logic                degen,
  output logic [2:0][W-1:0]   o_out,
  output logic [2:0][W:0]     l_out,
  output logic [2*W+2:0]      h_out,
  output logic [2*W+1:0]      a_out
);

  localparam int LW = W + 1;
  localparam int PW = 2 * LW;
  localparam int AW = 2 * W + 2;
  localparam int HW = 2 * W + 3;
  localparam int K  = W + 1;
  localparam int MW = 2 * K;
  localparam int RW = 2 * MW;
  localparam int DW = RW + 1;

  logic                v1, v2, v3, v4, v5, v6;
  logic [2:0][W-1:0]   o1, o2, o3, o4, o5, o6;
  logic [2:0][LW-1:0]  l1, l2, l3, l4, l5, l6;
  logic [2:0][LW-1:0]  w1;
  logic [W-2:0]        r1;

  logic [2:0][PW-1:0]  ll2, lw2, ww2;
  logic [2*W-3:0]      rr2;

  logic [AW-1:0]       a3, a4, a5, a6;
  logic [HW-1:0]       h3, h4, h5, h6;
  logic [HW-1:0]       c3;

  logic [MW-1:0]       habs4, cabs4;
  logic                cneg4, cneg5, cneg6;
  logic                degen4, degen5, degen6;
  logic [HW-1:0]       hn, cn;

  logic [2*K-1:0]      hll5, hlh5, hhh5, all5, alh5, ahl5, ahh5;
  logic [RW-1:0]       hsq6, acm6;
  logic [DW-1:0]       disc;

  always_comb begin
    hn   = h3[HW-1] ? -h3 : h3;
    cn   = c3[HW-1] ? -c3 : c3;
    disc = cneg6 ? DW'(hsq6) + DW'(acm6) : DW'(hsq6) - DW'(acm6);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      v5    <= 1'b0;
      v6    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      v5    <= v4;
      v6    <= v5;
      valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        l1[i]  <= LW'($signed(p_pt[i])) - LW'($signed(o_pt[i]));
        w1[i]  <= LW'($signed(o_pt[i])) - LW'($signed(c_pt[i]));
        ll2[i] <= $signed(l1[i]) * $signed(l1[i]);
        lw2[i] <= $signed(l1[i]) * $signed(w1[i]);
        ww2[i] <= $signed(w1[i]) * $signed(w1[i]);
      end
      o1  <= o_pt;
      r1  <= rad;
      rr2 <= r1 * r1;
      o2  <= o1;
      l2  <= l1;

      a3 <= ll2[0] + ll2[1] + ll2[2];
      h3 <= HW'($signed(lw2[0])) + HW'($signed(lw2[1])) + HW'($signed(lw2[2]));
      c3 <= HW'($signed(ww2[0])) + HW'($signed(ww2[1])) + HW'($signed(ww2[2]))
            - HW'(rr2);
      o3 <= o2;
      l3 <= l2;

      habs4  <= hn[MW-1:0];
      cabs4  <= cn[MW-1:0];
      cneg4  <= c3[HW-1];
      degen4 <= (a3 == '0);
      a4     <= a3;
      h4     <= h3;
      o4     <= o3;
      l4     <= l3;

      // h square and a*|c| product split into halves to keep each multiplier narrow
      hll5   <= habs4[K-1:0] * habs4[K-1:0];
      hlh5   <= habs4[K-1:0] * habs4[MW-1:K];
      hhh5   <= habs4[MW-1:K] * habs4[MW-1:K];
      all5   <= a4[K-1:0] * cabs4[K-1:0];
      alh5   <= a4[K-1:0] * cabs4[MW-1:K];
      ahl5   <= a4[MW-1:K] * cabs4[K-1:0];
      ahh5   <= a4[MW-1:K] * cabs4[MW-1:K];
      cneg5  <= cneg4;
      degen5 <= degen4;
      a5     <= a4;
      h5     <= h4;
      o5     <= o4;
      l5     <= l4;

      hsq6   <= (RW'(hhh5) << MW) + (RW'(hlh5) << (K + 1)) + RW'(hll5);
      acm6   <= (RW'(ahh5) << MW) + ((RW'(alh5) + RW'(ahl5)) << K) + RW'(all5);
      cneg6  <= cneg5;
      degen6 <= degen5;
      a6     <= a5;
      h6     <= h5;
      o6     <= o5;
      l6     <= l5;

      // negative discriminant: tangent, root taken of zero
      radicand <= disc[DW-1] ? '0 : disc[RW-1:0];
      clamped  <= disc[DW-1];
      degen    <= degen6;
      a_out    <= a6;
      h_out    <= h6;
      o_out    <= o6;
      l_out    <= l6;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ssep_sqrt.sv @@
`default_nettype none

// Floor square root, one result bit per stage.
module ssep_sqrt #(
  parameter int RW     = 4 * ssep_pkg::COORD_WIDTH_DEF + 4,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RW-1:0]     rad,
  input  logic [SIDE_W-1:0] side_in,
  output logic              valid,
  output logic [RW/2-1:0]   root,
  output logic [SIDE_W-1:0] side_out
);

  localparam int SW = RW / 2;

  logic [RW-1:0]     rem_q  [SW];
  logic [SW-1:0]     root_q [SW];
  logic              v_q    [SW];
  logic [SIDE_W-1:0] side_q [SW];

  for (genvar j = 0; j < SW; j++) begin : g_stage
    localparam int B = SW - 1 - j;
    logic [RW-1:0]     cur_rem;
    logic [SW-1:0]     cur_root;
    logic              cur_v;
    logic [SIDE_W-1:0] cur_side;
    logic [RW:0]       trial;

    if (j == 0) begin : g_first
      assign cur_rem  = rad;
      assign cur_root = '0;
      assign cur_v    = in_valid;
      assign cur_side = side_in;
    end else begin : g_next
      assign cur_rem  = rem_q[j-1];
      assign cur_root = root_q[j-1];
      assign cur_v    = v_q[j-1];
      assign cur_side = side_q[j-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = ((RW + 1)'(cur_root) << (B + 1)) + ((RW + 1)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else if (en) begin
        v_q[j] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[j] <= cur_side;
        if ({1'b0, cur_rem} >= trial) begin
          rem_q[j]  <= cur_rem - trial[RW-1:0];
          root_q[j] <= cur_root | (SW'(1) << B);
        end else begin
          rem_q[j]  <= cur_rem;
          root_q[j] <= cur_root;
        end
      end
    end
  end

  assign valid    = v_q[SW-1];
  assign root     = root_q[SW-1];
  assign side_out = side_q[SW-1];

endmodule

`default_nettype wire

@@ rtl/core/ssep_scale.sv @@
`default_nettype none

// n = -h - s, then |L| * |n| per axis and the rounding numerator 2|p| + a.
module ssep_scale #(
  parameter int W      = ssep_pkg::COORD_WIDTH_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2*W+1:0]        s,
  input  logic [2*W+2:0]        h,
  input  logic [2*W+1:0]        a,
  input  logic [2:0][W:0]       l,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  valid,
  output logic [2:0][3*W+4:0]   num,
  output logic [2*W+2:0]        den,
  output logic [2:0]            neg,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int LW   = W + 1;
  localparam int AW   = 2 * W + 2;
  localparam int NW   = 2 * W + 4;
  localparam int NAW  = 2 * W + 3;
  localparam int NL   = W + 2;
  localparam int NH   = NAW - NL;
  localparam int MMW  = 3 * W + 3;
  localparam int NUMW = 3 * W + 5;

  logic [NW-1:0]          nfull, nabs;
  logic [2:0][LW-1:0]     lmag;

  logic                   va, vb;
  logic [NAW-1:0]         nabs_a;
  logic                   nneg_a;
  logic [2:0][LW-1:0]     labs_a;
  logic [2:0]             lneg_a;
  logic [AW-1:0]          a_a, a_b;
  logic [SIDE_W-1:0]      side_a, side_b;

  logic [2:0][LW+NL-1:0]  pl_b;
  logic [2:0][LW+NH-1:0]  ph_b;
  logic [2:0]             neg_b;
  logic [2:0][MMW-1:0]    m_b;

  always_comb begin
    nfull = -NW'($signed(h)) - NW'(s);
    nabs  = nfull[NW-1] ? -nfull : nfull;
    for (int i = 0; i < 3; i++) begin
      lmag[i] = l[i][LW-1] ? -l[i] : l[i];
      m_b[i]  = (MMW'(ph_b[i]) << NL) + MMW'(pl_b[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      vb    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      va    <= in_valid;
      vb    <= va;
      valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nabs_a <= nabs[NAW-1:0];
      nneg_a <= nfull[NW-1];
      a_a    <= a;
      side_a <= side_in;
      for (int i = 0; i < 3; i++) begin
        labs_a[i] <= lmag[i];
        lneg_a[i] <= l[i][LW-1];
        pl_b[i]   <= labs_a[i] * nabs_a[NL-1:0];
        ph_b[i]   <= labs_a[i] * nabs_a[NAW-1:NL];
        neg_b[i]  <= lneg_a[i] ^ nneg_a;
        // round half away from zero: (2|p| + a) / 2a
        num[i]    <= (NUMW'(m_b[i]) << 1) + NUMW'(a_b);
      end
      a_b      <= a_a;
      side_b   <= side_a;
      den      <= {a_b, 1'b0};
      neg      <= neg_b;
      side_out <= side_b;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ssep_div.sv @@
`default_nettype none

// Restoring divider, three lanes sharing one divisor. The quotient is kept
// to W+1 bits; anything larger is flagged, as it saturates in any case.
module ssep_div #(
  parameter int W      = ssep_pkg::COORD_WIDTH_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2:0][3*W+4:0]   num,
  input  logic [2*W+2:0]        den,
  input  logic [SIDE_W-1:0]     side_in,
  output logic                  valid,
  output logic [2:0][W:0]       quo,
  output logic [2:0]            ovf,
  output logic [SIDE_W-1:0]     side_out
);

  localparam int NUMW = 3 * W + 5;
  localparam int DVW  = 2 * W + 3;
  localparam int QB   = W + 1;

  logic                 v_s;
  logic [2:0][NUMW-1:0] rem_s;
  logic [DVW-1:0]       den_s;
  logic [2:0]           ovf_s;
  logic [SIDE_W-1:0]    side_s;

  logic                 v_q    [QB];
  logic [2:0][NUMW-1:0] rem_q  [QB];
  logic [2:0][QB-1:0]   q_q    [QB];
  logic [DVW-1:0]       den_q  [QB];
  logic [2:0]           ovf_q  [QB];
  logic [SIDE_W-1:0]    side_q [QB];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_s <= 1'b0;
    end else if (en) begin
      v_s <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s  <= num;
      den_s  <= den;
      side_s <= side_in;
      for (int i = 0; i < 3; i++) begin
        ovf_s[i] <= num[i] >= (NUMW'(den) << QB);
      end
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int B = QB - 1 - j;
    logic                 cur_v;
    logic [2:0][NUMW-1:0] cur_rem;
    logic [2:0][QB-1:0]   cur_q;
    logic [DVW-1:0]       cur_den;
    logic [2:0]           cur_ovf;
    logic [SIDE_W-1:0]    cur_side;
    logic [NUMW-1:0]      sub;

    if (j == 0) begin : g_first
      assign cur_v    = v_s;
      assign cur_rem  = rem_s;
      assign cur_q    = '0;
      assign cur_den  = den_s;
      assign cur_ovf  = ovf_s;
      assign cur_side = side_s;
    end else begin : g_next
      assign cur_v    = v_q[j-1];
      assign cur_rem  = rem_q[j-1];
      assign cur_q    = q_q[j-1];
      assign cur_den  = den_q[j-1];
      assign cur_ovf  = ovf_q[j-1];
      assign cur_side = side_q[j-1];
    end

    assign sub = NUMW'(cur_den) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else if (en) begin
        v_q[j] <= cur_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[j]  <= cur_den;
        ovf_q[j]  <= cur_ovf;
        side_q[j] <= cur_side;
        for (int i = 0; i < 3; i++) begin
          if (cur_rem[i] >= sub) begin
            rem_q[j][i] <= cur_rem[i] - sub;
            q_q[j][i]   <= cur_q[i] | (QB'(1) << B);
          end else begin
            rem_q[j][i] <= cur_rem[i];
            q_q[j][i]   <= cur_q[i];
          end
        end
      end
    end
  end

  assign valid    = v_q[QB-1];
  assign quo      = q_q[QB-1];
  assign ovf      = ovf_q[QB-1];
  assign side_out = side_q[QB-1];

endmodule

`default_nettype wire

@@ rtl/core/segment_sphere_entry_point_unit.sv @@
`default_nettype none
// Pipeline from request to result:
//   7 setup stages, 2*COORD_WIDTH+2 square root stages, 3 scaling stages,
//   COORD_WIDTH+2 divider stages and the output register.
// Throughput: one request per cycle; a stall on the output holds the whole pipe.
// Reset: synchronous, clears every stage valid bit; data registers keep contents.

module segment_sphere_entry_point_unit #(
  parameter int COORD_WIDTH = ssep_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] outside_x,
  input  logic signed [COORD_WIDTH-1:0] outside_y,
  input  logic signed [COORD_WIDTH-1:0] outside_z,
  input  logic signed [COORD_WIDTH-1:0] inside_x,
  input  logic signed [COORD_WIDTH-1:0] inside_y,
  input  logic signed [COORD_WIDTH-1:0] inside_z,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic signed [COORD_WIDTH-1:0] center_z,
  input  logic        [COORD_WIDTH-2:0] sphere_radius,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] hit_x,
  output logic signed [COORD_WIDTH-1:0] hit_y,
  output logic signed [COORD_WIDTH-1:0] hit_z,
  output logic                          tangent_clamped,
  output logic                          degenerate_segment
);

  import ssep_pkg::*;

  localparam int W     = COORD_WIDTH;
  localparam int LW    = W + 1;
  localparam int AW    = 2 * W + 2;
  localparam int HW    = 2 * W + 3;
  localparam int RW    = 4 * W + 4;
  localparam int SW    = RW / 2;
  localparam int NUMW  = 3 * W + 5;
  localparam int DVW   = 2 * W + 3;
  localparam int QB    = W + 1;
  localparam int FW    = $bits(ssep_flags_t);
  localparam int SIDE1 = FW + 3 * W + 3 * LW + HW + AW;
  localparam int SIDE2 = FW + 3 * W;
  localparam int SIDE3 = SIDE2 + 3;
  localparam int XW    = W + 3;

  logic en;

  logic                 qd_valid, qd_clamped, qd_degen;
  logic [RW-1:0]        qd_rad;
  logic [2:0][W-1:0]    qd_o;
  logic [2:0][LW-1:0]   qd_l;
  logic [HW-1:0]        qd_h;
  logic [AW-1:0]        qd_a;
  ssep_flags_t          qd_flags;

  logic                 sq_valid;
  logic [SW-1:0]        sq_root;
  logic [SIDE1-1:0]     sq_side_in, sq_side_out;
  ssep_flags_t          sq_flags;
  logic [2:0][W-1:0]    sq_o;
  logic [2:0][LW-1:0]   sq_l;
  logic [HW-1:0]        sq_h;
  logic [AW-1:0]        sq_a;

  logic                 sc_valid;
  logic [2:0][NUMW-1:0] sc_num;
  logic [DVW-1:0]       sc_den;
  logic [2:0]           sc_neg;
  logic [SIDE2-1:0]     sc_side;

  logic                 dv_valid;
  logic [2:0][QB-1:0]   dv_quo;
  logic [2:0]           dv_ovf;
  logic [SIDE3-1:0]     dv_side;
  logic [2:0]           dv_neg;
  ssep_flags_t          dv_flags;
  logic [2:0][W-1:0]    dv_o;

  logic [2:0][XW-1:0]   qx, sum;
  logic [2:0][W-1:0]    hit;
  logic [2:0]           sat_hi, sat_lo;

  // A held result freezes every stage.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  ssep_quad #(.W(W)) u_quad (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .o_pt     ({outside_z, outside_y, outside_x}),
    .p_pt     ({inside_z, inside_y, inside_x}),
    .c_pt     ({center_z, center_y, center_x}),
    .rad      (sphere_radius),
    .valid    (qd_valid),
    .radicand (qd_rad),
    .clamped  (qd_clamped),
    .degen    (qd_degen),
    .o_out    (qd_o),
    .l_out    (qd_l),
    .h_out    (qd_h),
    .a_out    (qd_a)
  );

  assign qd_flags.tangent = qd_clamped;
  assign qd_flags.degen   = qd_degen;
  assign sq_side_in       = {qd_flags, qd_o, qd_l, qd_h, qd_a};

  ssep_sqrt #(.RW(RW), .SIDE_W(SIDE1)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (qd_valid),
    .rad      (qd_rad),
    .side_in  (sq_side_in),
    .valid    (sq_valid),
    .root     (sq_root),
    .side_out (sq_side_out)
  );

  assign {sq_flags, sq_o, sq_l, sq_h, sq_a} = sq_side_out;

  ssep_scale #(.W(W), .SIDE_W(SIDE2)) u_scale (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sq_valid),
    .s        (sq_root),
    .h        (sq_h),
    .a        (sq_a),
    .l        (sq_l),
    .side_in  ({sq_flags, sq_o}),
    .valid    (sc_valid),
    .num      (sc_num),
    .den      (sc_den),
    .neg      (sc_neg),
    .side_out (sc_side)
  );

  ssep_div #(.W(W), .SIDE_W(SIDE3)) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (sc_valid),
    .num      (sc_num),
    .den      (sc_den),
    .side_in  ({sc_neg, sc_side}),
    .valid    (dv_valid),
    .quo      (dv_quo),
    .ovf      (dv_ovf),
    .side_out (dv_side)
  );

  assign {dv_neg, dv_flags, dv_o} = dv_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qx[i]     = XW'(dv_quo[i]);
      sum[i]    = XW'($signed(dv_o[i])) + (dv_neg[i] ? -qx[i] : qx[i]);
      sat_hi[i] = !sum[i][XW-1] && (sum[i][XW-1:W-1] != '0);
      sat_lo[i] = sum[i][XW-1] && (sum[i][XW-1:W-1] != '1);
      if (dv_flags.degen) begin
        hit[i] = dv_o[i];
      end else if (dv_ovf[i]) begin
        hit[i] = {dv_neg[i], {(W-1){!dv_neg[i]}}};
      end else if (sat_hi[i]) begin
        hit[i] = {1'b0, {(W-1){1'b1}}};
      end else if (sat_lo[i]) begin
        hit[i] = {1'b1, {(W-1){1'b0}}};
      end else begin
        hit[i] = sum[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_x              <= hit[0];
      hit_y              <= hit[1];
      hit_z              <= hit[2];
      tangent_clamped    <= dv_flags.tangent && !dv_flags.degen;
      degenerate_segment <= dv_flags.degen;
    end
  end

`ifndef SYNTHESIS
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tangent_clamped && degenerate_segment))
    else $error("tangent and degenerate flags both set");

  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(dv_valid))
    else $error("pipeline moved while output held");

  a_pipe_adv: assert property (@(posedge clk) disable iff (rst)
    dv_valid && en |=> out_valid)
    else $error("divider result lost on way to output");
`endif

endmodule

`default_nettype wire

@@ dv/segment_sphere_entry_point_unit_test.sv @@
module segment_sphere_entry_point_unit_test;
  localparam int CW = ssep_pkg::COORD_WIDTH_DEF;
  localparam int LATENCY = 3 * CW + 15;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [CW-1:0] ox, oy, oz, px, py, pz, cx, cy, cz;
    logic [CW-2:0] rad;
  } segment_t;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
    ssep_pkg::ssep_flags_t flags;
  } entry_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [CW-1:0] outside_x = 0, outside_y = 0, outside_z = 0;
  logic signed [CW-1:0] inside_x = 0, inside_y = 0, inside_z = 0;
  logic signed [CW-1:0] center_x = 0, center_y = 0, center_z = 0;
  logic [CW-2:0] sphere_radius = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [CW-1:0] hit_x, hit_y, hit_z;
  logic tangent_clamped, degenerate_segment;

  entry_t expected_entries[$];
  int errors = 0;
  longint cycles = 0;
  bit idle_enable = 1;
  int hold_off = 0;

  segment_sphere_entry_point_unit u_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Exact integer solve of the nearer root, 256-bit signed intermediates.
  function automatic entry_t predict_entry(segment_t s);
    logic signed [255:0] o[3], l[3], w[3], a, h, c, disc, sq, n, p, m, q, sum, rem, bitv;
    logic signed [255:0] maxv, minv;
    entry_t e;
    o[0] = s.ox; o[1] = s.oy; o[2] = s.oz;
    l[0] = 256'(s.px) - o[0]; l[1] = 256'(s.py) - o[1]; l[2] = 256'(s.pz) - o[2];
    w[0] = o[0] - 256'(s.cx); w[1] = o[1] - 256'(s.cy); w[2] = o[2] - 256'(s.cz);
    a = 0; h = 0; c = 0;
    for (int i = 0; i < 3; i++) begin
      a += l[i] * l[i];
      h += l[i] * w[i];
      c += w[i] * w[i];
    end
    c -= $signed({1'b0, s.rad}) * $signed({1'b0, s.rad});
    e.flags.tangent = 0;
    e.flags.degen = 0;
    if (a == 0) begin
      e.x = s.ox; e.y = s.oy; e.z = s.oz;
      e.flags.degen = 1;
      return e;
    end
    disc = h * h - a * c;
    if (disc < 0) begin
      disc = 0;
      e.flags.tangent = 1;
    end
    sq = 0;
    rem = disc;
    bitv = 256'sd1 <<< 252;
    while (bitv > rem) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (rem >= sq + bitv) begin
        rem -= sq + bitv;
        sq = (sq >>> 1) + bitv;
      end else begin
        sq = sq >>> 1;
      end
      bitv = bitv >>> 2;
    end
    n = -h - sq;
    maxv = (256'sd1 <<< (CW - 1)) - 1;
    minv = -(256'sd1 <<< (CW - 1));
    for (int i = 0; i < 3; i++) begin
      p = l[i] * n;
      m = (p < 0) ? -p : p;
      q = (2 * m + a) / (2 * a);
      if (p < 0) q = -q;
      sum = o[i] + q;
      if (sum > maxv) sum = maxv;
      if (sum < minv) sum = minv;
      if (i == 0) e.x = sum[CW-1:0];
      else if (i == 1) e.y = sum[CW-1:0];
      else e.z = sum[CW-1:0];
    end
    return e;
  endfunction

  task automatic send_segment(segment_t s);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    outside_x <= s.ox; outside_y <= s.oy; outside_z <= s.oz;
    inside_x <= s.px; inside_y <= s.py; inside_z <= s.pz;
    center_x <= s.cx; center_y <= s.cy; center_z <= s.cz;
    sphere_radius <= s.rad;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    expected_entries.push_back(predict_entry(s));
  endtask

  // Receiver stall: random bursts, plus a long hold-off on request.
  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_stall <= 1;
        hold_off--;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13);
        out_stall <= 1;
        repeat (burst - 1) @(posedge clk);
      end else begin
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    entry_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_entries.size() == 0) begin
        $display("%0t: unexpected result %h %h %h", $time, hit_x, hit_y, hit_z);
        errors++;
      end else begin
        e = expected_entries.pop_front();
        if (hit_x !== e.x || hit_y !== e.y || hit_z !== e.z ||
            tangent_clamped !== e.flags.tangent || degenerate_segment !== e.flags.degen) begin
          $display("%0t: expected %h %h %h t%b d%b, actual %h %h %h t%b d%b", $time,
                   e.x, e.y, e.z, e.flags.tangent, e.flags.degen,
                   hit_x, hit_y, hit_z, tangent_clamped, degenerate_segment);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [CW-1:0] pick_coord(int range_sel);
    case (range_sel)
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      default: return $signed($urandom_range(0, 1 << 14)) - (1 << 13);
    endcase
  endfunction

  function automatic segment_t random_segment();
    segment_t s;
    int r;
    r = $urandom_range(0, 4);
    s.cx = pick_coord(r); s.cy = pick_coord(r); s.cz = pick_coord(r);
    s.rad = (r == 0) ? (CW-1)'($urandom) : (CW-1)'($urandom_range(1, 1 << 20));
    s.ox = s.cx + pick_coord(r); s.oy = s.cy + pick_coord(r); s.oz = s.cz + pick_coord(r);
    s.px = s.cx + pick_coord(r); s.py = s.cy + pick_coord(r); s.pz = s.cz + pick_coord(r);
    if ($urandom_range(0, 19) == 0) begin
      s.px = s.ox; s.py = s.oy; s.pz = s.oz;
    end
    return s;
  endfunction

  task automatic wait_drained();
    in_valid <= 0;
    while (expected_entries.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    segment_t s;
    logic signed [CW-1:0] mx, mn;
    mx = {1'b0, {(CW-1){1'b1}}};
    mn = {1'b1, {(CW-1){1'b0}}};
    // plain entry along x
    s = '{32'sh50000, 0, 0, 0, 0, 0, 0, 0, 0, 31'h10000};
    send_segment(s);
    // zero-length segment
    s = '{32'sh1234, -5, 7, 32'sh1234, -5, 7, 0, 0, 0, 31'h10000};
    send_segment(s);
    // line misses sphere: clamped
    s = '{32'sh50000, 32'sh50000, 0, -32'sh50000, 32'sh50000, 0, 0, 0, 0, 31'h10000};
    send_segment(s);
    // extremes, saturation
    s = '{mn, mn, mn, mx, mx, mx, mx, mx, mx, '1};
    send_segment(s);
    s = '{mx, mn, mx, mn, mx, mn, mn, mx, mn, 0};
    send_segment(s);
    s = '{mx, mx, mx, mx, mx, mx, mn, mn, mn, '1};
    send_segment(s);
    s = '{-1, -1, -1, 0, 0, 0, 0, 0, 0, 0};
    send_segment(s);
    s = '{mn, 0, 0, mx, 0, 0, 0, 0, 0, 31'h1};
    send_segment(s);
    s = '{0, 0, 0, 1, 0, 0, 0, 0, 0, '1};
    send_segment(s);
    s = '{mx, mx, mx, mx, mx, mx, 0, 0, 0, '1};
    send_segment(s);
  endtask

  task automatic test_random(int count);
    repeat (count) send_segment(random_segment());
  endtask

  task automatic test_backpressure();
    hold_off = 300;
    repeat (150) send_segment(random_segment());
    wait_drained();
  endtask

  task automatic test_no_idle();
    idle_enable = 0;
    repeat (100) send_segment(random_segment());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(250);
    test_backpressure();
    test_random(100);
    test_no_idle();
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/ssep_pkg.sv
rtl/core/ssep_quad.sv
rtl/core/ssep_sqrt.sv
rtl/core/ssep_scale.sv
rtl/core/ssep_div.sv
rtl/core/segment_sphere_entry_point_unit.sv
dv/segment_sphere_entry_point_unit_test.sv
